/* src/bls_pkg.sv */
package bls_pkg;

	localparam int WORD_W  = 32;
	localparam int LIMIT_W = 7;
	localparam int LEVEL_W = 7;

	// request kinds
	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	// error codes
	localparam logic [1:0] ERR_OK        = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
	localparam logic [1:0] ERR_BAD_INDEX = 2'd3;

	localparam logic [LIMIT_W-1:0]       LIMIT_RESET = 7'd64;
	localparam logic signed [WORD_W-1:0] NEG_ONE     = -32'sd1;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [WORD_W-1:0] push_value;
		logic [6:0]               depth_index;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [1:0]               error_code;
		logic [LEVEL_W-1:0]       level;
		logic                     is_empty;
		logic                     is_full;
		logic signed [WORD_W-1:0] top_value;
	} rsp_t;

	// where the read word of a result comes from
	typedef enum logic [1:0] {
		RD_NONE,
		RD_HELD,
		RD_RAM
	} rd_sel_t;

endpackage

/* src/bls_ram.sv */
module bls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/bounded_lifo_stack_unit.sv */
// bounded lifo stack of signed 32-bit words, held in one single-port-write ram
// command channel: an item is taken at a rising edge with start high and busy
//   low; busy stays low, so a push, pop or peek can be issued every cycle
// result channel: done is high for exactly one cycle, in the cycle after the
//   item was taken, with rsp holding read word, error code, level, empty and
//   full flags and the top word; the receiver cannot hold results off
// throughput is one item per cycle: each item makes at most one ram access
//   (push writes, pop reads the new top, peek reads its entry), and the top
//   word is kept in a register that is forwarded from the ram read port when
//   a pop has just fetched the next entry
// configuration: cfg_we writes cfg_wdata into the stack limit; the effective
//   limit is the value clamped to 1..DEPTH; write only while no result is due
// reset: arst_n clears the level to zero (stack empty) and sets the limit to
//   its reset value; ram contents stay undefined, no clearing pass is needed
//   since only written entries can ever be read
module bounded_lifo_stack_unit #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  bls_pkg::cmd_t                cmd,
	input  logic                         cfg_we,
	input  logic [bls_pkg::LIMIT_W-1:0]  cfg_wdata,
	output logic                         done,
	output bls_pkg::rsp_t                rsp
);

	import bls_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);                 // level width
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // ram address width
	localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;     // compare width

	// configuration and stack state
	logic [LIMIT_W-1:0]       stack_limit_q;
	logic [LW-1:0]            level_q;
	logic signed [WORD_W-1:0] top_q;

	// result stage
	logic                     valid_s1;
	logic [1:0]               err_s1;
	rd_sel_t                  sel_s1;
	logic signed [WORD_W-1:0] hold_s1;
	logic                     top_ram_s1;

	// decode
	logic                     acc;
	logic [CW-1:0]            lim_c;
	logic [CW-1:0]            cfg_ext;
	logic [CW-1:0]            level_ext;
	logic [CW-1:0]            idx_ext;
	logic                     full_c;
	logic signed [WORD_W-1:0] top_eff;
	logic [1:0]               err_c;
	rd_sel_t                  sel_c;
	logic [LW-1:0]            level_nxt;
	logic                     top_ram_c;
	logic                     push_ok;

	// ram port
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [WORD_W-1:0]        ram_rdata;

	// every request touches the ram at most once, so nothing ever stalls
	assign busy = 1'b0;
	assign acc  = start && !busy;

	// effective limit, clamped to 1..DEPTH
	assign cfg_ext   = CW'(stack_limit_q);
	assign level_ext = CW'(level_q);
	assign idx_ext   = CW'(cmd.depth_index);

	always_comb begin
		priority if (cfg_ext == '0) begin
			lim_c = CW'(1);
		end else if (cfg_ext > CW'(DEPTH)) begin
			lim_c = CW'(DEPTH);
		end else begin
			lim_c = cfg_ext;
		end
	end

	assign full_c = (level_ext >= lim_c);

	// top word as of the last item taken: a pop in the result stage brings
	// the next entry straight from the ram read port
	assign top_eff = (valid_s1 && top_ram_s1) ? $signed(ram_rdata) : top_q;

	// request decode and ram access
	always_comb begin
		err_c     = ERR_OK;
		sel_c     = RD_NONE;
		level_nxt = level_q;
		top_ram_c = 1'b0;
		push_ok   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = AW'(level_q);
		ram_re    = 1'b0;
		ram_raddr = AW'(level_q - LW'(2));
		unique case (cmd.req_type)
			REQ_PUSH: begin
				if (full_c) begin
					err_c = ERR_OVERFLOW;
				end else begin
					push_ok   = 1'b1;
					ram_we    = acc;
					level_nxt = level_q + LW'(1);
				end
			end
			REQ_POP: begin
				if (level_q == '0) begin
					err_c = ERR_UNDERFLOW;
				end else begin
					sel_c     = RD_HELD;
					level_nxt = level_q - LW'(1);
					// fetch the entry below the top unless the stack drains
					if (level_q > LW'(1)) begin
						top_ram_c = 1'b1;
						ram_re    = acc;
					end
				end
			end
			REQ_PEEK: begin
				if (idx_ext == '0 || idx_ext > level_ext) begin
					err_c = ERR_BAD_INDEX;
				end else begin
					sel_c     = RD_RAM;
					ram_re    = acc;
					ram_raddr = AW'(level_ext - idx_ext);
				end
			end
			default: begin
				// request with no meaning: state kept, read word -1, no error
			end
		endcase
	end

	bls_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.push_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			stack_limit_q <= cfg_wdata;
		end
	end

	// level and result-stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			valid_s1   <= 1'b0;
			top_ram_s1 <= 1'b0;
		end else begin
			valid_s1   <= acc;
			top_ram_s1 <= acc && top_ram_c;
			if (acc) begin
				level_q <= level_nxt;
			end
		end
	end

	// top word register and result payload
	always_ff @(posedge clk) begin
		if (acc && push_ok) begin
			top_q <= cmd.push_value;
		end else begin
			top_q <= top_eff;
		end
		if (acc) begin
			err_s1  <= err_c;
			sel_s1  <= sel_c;
			hold_s1 <= top_eff;     // popped word is the current top
		end
	end

	// result
	assign done = valid_s1;

	always_comb begin
		rsp.error_code = err_s1;
		rsp.level      = LEVEL_W'(level_q);
		rsp.is_empty   = (level_q == '0);
		rsp.is_full    = full_c;
		rsp.top_value  = (level_q == '0) ? NEG_ONE : top_eff;
		unique case (sel_s1)
			RD_HELD: rsp.read_value = hold_s1;
			RD_RAM:  rsp.read_value = $signed(ram_rdata);
			default: rsp.read_value = NEG_ONE;
		endcase
	end

	// checks
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(DEPTH))
		else $error("level above depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done)
		else $error("no result after accepted item");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.req_type == REQ_PUSH && !full_c) |=> (level_q == $past(level_q) + LW'(1)))
		else $error("push did not grow the stack");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.error_code == ERR_UNDERFLOW) |-> (level_q == '0))
		else $error("underflow reported on non-empty stack");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (level_ext < lim_c))
		else $error("ram write past the limit");

endmodule
